FILE: src/ppi_pkg.sv
// shared types, constants and the sine table for the planar pose integrator
// used by ppi_regs, ppi_ctrl, ppi_dp and planar_pose_integrator; no dependencies
package ppi_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int QBITS = SINE_TABLE_BITS - 2;
	localparam int QN = 1 << QBITS;
	localparam int QIDX_W = QBITS + 1;

	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_BODY_VEL_X = 2'd0;
	localparam logic [1:0] REG_BODY_VEL_Y = 2'd1;
	localparam logic [1:0] REG_YAW_RATE = 2'd2;

	localparam logic [31:0] RST_BODY_VEL_X = 32'd6554;
	localparam logic [31:0] RST_BODY_VEL_Y = 32'hFFFF_E666;
	localparam logic [31:0] RST_YAW_RATE = 32'd68354049;

	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	typedef logic [QIDX_W-1:0] qidx_t;
	typedef logic [16:0] qsine_tab_t [QN+1];

	typedef enum logic [2:0] {
		MUL_VX_C,
		MUL_VY_S,
		MUL_VX_S,
		MUL_VY_C,
		MUL_WX_DT,
		MUL_WY_DT,
		MUL_WR_DT
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_WX_SET,
		ACC_WX_SUB,
		ACC_WY_SET,
		ACC_WY_ADD,
		ACC_POS_X,
		ACC_POS_Y,
		ACC_HEAD
	} acc_op_t;

	typedef struct packed {
		logic dt_ld;
		logic sin_ld;
		logic cos_ld;
		mul_sel_t mul_sel;
		acc_op_t acc_op;
		logic out_ld;
	} ppi_cmd_t;

	typedef struct packed {
		logic signed [31:0] body_vel_x;
		logic signed [31:0] body_vel_y;
		logic signed [31:0] yaw_rate;
	} ppi_cfg_t;

	// quarter-wave sine in q16, taylor series in q30 up to the x^13 term
	function automatic qsine_tab_t build_qsine();
		qsine_tab_t tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] r;
		for (int j = 0; j <= QN; j++) begin
			x = (64'(j) * HALF_PI_Q30) >> QBITS;
			x2 = (x * x) >> 30;
			t = ONE_Q30;
			t = ONE_Q30 - ((x2 * t) >> 30) / 156;
			t = ONE_Q30 - ((x2 * t) >> 30) / 110;
			t = ONE_Q30 - ((x2 * t) >> 30) / 72;
			t = ONE_Q30 - ((x2 * t) >> 30) / 42;
			t = ONE_Q30 - ((x2 * t) >> 30) / 20;
			t = ONE_Q30 - ((x2 * t) >> 30) / 6;
			r = (((x * t) >> 30) + 64'd8192) >> 14;
			tab[j] = r[16:0];
		end
		return tab;
	endfunction

	localparam qsine_tab_t QSINE_TAB = build_qsine();

	// full-turn sine in q1.16 from the top bits of a binary angle
	function automatic logic signed [17:0] table_sine(input logic [31:0] angle);
		logic [SINE_TABLE_BITS-1:0] k;
		logic [1:0] q;
		qidx_t j;
		logic signed [17:0] s;
		k = angle[31 -: SINE_TABLE_BITS];
		q = k[SINE_TABLE_BITS-1 -: 2];
		j = {1'b0, k[QBITS-1:0]};
		if (q[0]) begin
			j = qidx_t'(QN) - j;
		end
		s = {1'b0, QSINE_TAB[j]};
		return q[1] ? -s : s;
	endfunction

endpackage

FILE: src/ppi_regs.sv
// apb configuration registers: body velocities and yaw rate
// depends on ppi_pkg
module ppi_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ppi_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output ppi_pkg::ppi_cfg_t           cfg
);

	logic [31:0] vx_q;
	logic [31:0] vy_q;
	logic [31:0] wr_q;
	logic        wr_en;
	logic [1:0]  idx;

	assign idx = paddr[3:2];
	assign wr_en = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vx_q <= ppi_pkg::RST_BODY_VEL_X;
			vy_q <= ppi_pkg::RST_BODY_VEL_Y;
			wr_q <= ppi_pkg::RST_YAW_RATE;
		end else if (wr_en) begin
			case (idx)
				ppi_pkg::REG_BODY_VEL_X: vx_q <= pwdata;
				ppi_pkg::REG_BODY_VEL_Y: vy_q <= pwdata;
				ppi_pkg::REG_YAW_RATE:   wr_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			ppi_pkg::REG_BODY_VEL_X: prdata = vx_q;
			ppi_pkg::REG_BODY_VEL_Y: prdata = vy_q;
			ppi_pkg::REG_YAW_RATE:   prdata = wr_q;
			default:                 prdata = 32'd0;
		endcase
	end

	assign cfg.body_vel_x = vx_q;
	assign cfg.body_vel_y = vy_q;
	assign cfg.yaw_rate = wr_q;

endmodule

FILE: src/ppi_ctrl.sv
// sequencer for one tick: table reads, seven multiply steps, pose hand-off
// depends on ppi_pkg
module ppi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	output logic              tick_ready,
	output logic              pose_valid,
	input  logic              pose_ready,
	output ppi_pkg::ppi_cmd_t cmd
);

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_SIN  = 12'b0000_0000_0010,
		ST_COS  = 12'b0000_0000_0100,
		ST_MUL0 = 12'b0000_0000_1000,
		ST_MUL1 = 12'b0000_0001_0000,
		ST_MUL2 = 12'b0000_0010_0000,
		ST_MUL3 = 12'b0000_0100_0000,
		ST_MUL4 = 12'b0000_1000_0000,
		ST_MUL5 = 12'b0001_0000_0000,
		ST_MUL6 = 12'b0010_0000_0000,
		ST_HEAD = 12'b0100_0000_0000,
		ST_DONE = 12'b1000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || pose_ready;
	assign tick_ready = (state_q == ST_IDLE);
	assign pose_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd.dt_ld = 1'b0;
		cmd.sin_ld = 1'b0;
		cmd.cos_ld = 1'b0;
		cmd.mul_sel = ppi_pkg::MUL_VX_C;
		cmd.acc_op = ppi_pkg::ACC_NONE;
		cmd.out_ld = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.dt_ld = tick_valid;
				if (tick_valid) state_d = ST_SIN;
			end
			ST_SIN: begin
				cmd.sin_ld = 1'b1;
				state_d = ST_COS;
			end
			ST_COS: begin
				cmd.cos_ld = 1'b1;
				state_d = ST_MUL0;
			end
			ST_MUL0: begin
				cmd.mul_sel = ppi_pkg::MUL_VX_C;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul_sel = ppi_pkg::MUL_VY_S;
				cmd.acc_op = ppi_pkg::ACC_WX_SET;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_sel = ppi_pkg::MUL_VX_S;
				cmd.acc_op = ppi_pkg::ACC_WX_SUB;
				state_d = ST_MUL3;
			end
			ST_MUL3: begin
				cmd.mul_sel = ppi_pkg::MUL_VY_C;
				cmd.acc_op = ppi_pkg::ACC_WY_SET;
				state_d = ST_MUL4;
			end
			ST_MUL4: begin
				cmd.mul_sel = ppi_pkg::MUL_WX_DT;
				cmd.acc_op = ppi_pkg::ACC_WY_ADD;
				state_d = ST_MUL5;
			end
			ST_MUL5: begin
				cmd.mul_sel = ppi_pkg::MUL_WY_DT;
				cmd.acc_op = ppi_pkg::ACC_POS_X;
				state_d = ST_MUL6;
			end
			ST_MUL6: begin
				cmd.mul_sel = ppi_pkg::MUL_WR_DT;
				cmd.acc_op = ppi_pkg::ACC_POS_Y;
				state_d = ST_HEAD;
			end
			ST_HEAD: begin
				cmd.acc_op = ppi_pkg::ACC_HEAD;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.out_ld = slot_free;
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld) out_valid_q <= 1'b1;
			else if (pose_ready) out_valid_q <= 1'b0;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |=> state_q == ST_SIN)
		else $error("accepted request did not start the table read");

	a_head_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HEAD |=> state_q == ST_DONE)
		else $error("heading update not followed by hand-off");

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!out_valid_q || pose_ready))
		else $error("result loaded over an unread result");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |=> pose_valid)
		else $error("loaded result not presented");

endmodule

FILE: src/ppi_dp.sv
// datapath: sine table, one shared 34x25 multiplier, accumulators and pose state
// depends on ppi_pkg
module ppi_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  ppi_pkg::ppi_cmd_t cmd,
	input  ppi_pkg::ppi_cfg_t cfg,
	input  logic [23:0]       elapsed_time,
	output logic [31:0]       pose_x,
	output logic [31:0]       pose_y,
	output logic [31:0]       heading
);

	logic [23:0]        dt_q;
	logic signed [17:0] sin_q;
	logic signed [17:0] cos_q;
	logic signed [17:0] lut;
	logic signed [33:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [58:0] prod_q;
	logic signed [49:0] accx_q;
	logic signed [49:0] accy_q;
	logic signed [49:0] ext_prod;
	logic signed [49:0] rndx;
	logic signed [49:0] rndy;
	logic signed [33:0] wx;
	logic signed [33:0] wy;
	logic signed [58:0] prod_rnd;
	logic signed [42:0] disp;
	logic [31:0]        turn;
	logic signed [31:0] posx_q;
	logic signed [31:0] posy_q;
	logic [31:0]        head_q;
	logic signed [31:0] posx_next;
	logic signed [31:0] posy_next;
	logic [31:0]        px_out_q;
	logic [31:0]        py_out_q;
	logic [31:0]        hd_out_q;

	function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
		input logic signed [42:0] d);
		logic signed [43:0] r;
		r = {{12{a[31]}}, a} + {d[42], d};
		if (r[43:31] == {13{r[43]}}) return r[31:0];
		return r[43] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
	endfunction

	assign lut = ppi_pkg::table_sine(cmd.cos_ld ? head_q + ppi_pkg::QUARTER_TURN : head_q);

	always_comb begin
		case (cmd.mul_sel)
			ppi_pkg::MUL_VX_C: begin
				mul_a = {{2{cfg.body_vel_x[31]}}, cfg.body_vel_x};
				mul_b = {{7{cos_q[17]}}, cos_q};
			end
			ppi_pkg::MUL_VY_S: begin
				mul_a = {{2{cfg.body_vel_y[31]}}, cfg.body_vel_y};
				mul_b = {{7{sin_q[17]}}, sin_q};
			end
			ppi_pkg::MUL_VX_S: begin
				mul_a = {{2{cfg.body_vel_x[31]}}, cfg.body_vel_x};
				mul_b = {{7{sin_q[17]}}, sin_q};
			end
			ppi_pkg::MUL_VY_C: begin
				mul_a = {{2{cfg.body_vel_y[31]}}, cfg.body_vel_y};
				mul_b = {{7{cos_q[17]}}, cos_q};
			end
			ppi_pkg::MUL_WX_DT: begin
				mul_a = wx;
				mul_b = {1'b0, dt_q};
			end
			ppi_pkg::MUL_WY_DT: begin
				mul_a = wy;
				mul_b = {1'b0, dt_q};
			end
			ppi_pkg::MUL_WR_DT: begin
				mul_a = {{2{cfg.yaw_rate[31]}}, cfg.yaw_rate};
				mul_b = {1'b0, dt_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// round half up to q16.16 by bias and truncation
	assign ext_prod = prod_q[49:0];
	assign rndx = accx_q + 50'sd32768;
	assign rndy = accy_q + 50'sd32768;
	assign wx = rndx[49:16];
	assign wy = rndy[49:16];
	assign prod_rnd = prod_q + 59'sd32768;
	assign disp = prod_rnd[58:16];
	assign turn = prod_rnd[47:16];
	assign posx_next = add_sat(posx_q, disp);
	assign posy_next = add_sat(posy_q, disp);

	always_ff @(posedge clk) begin
		if (cmd.dt_ld) dt_q <= elapsed_time;
		if (cmd.sin_ld) sin_q <= lut;
		if (cmd.cos_ld) cos_q <= lut;
		prod_q <= mul_a * mul_b;
		case (cmd.acc_op)
			ppi_pkg::ACC_WX_SET: accx_q <= ext_prod;
			ppi_pkg::ACC_WX_SUB: accx_q <= accx_q - ext_prod;
			ppi_pkg::ACC_WY_SET: accy_q <= ext_prod;
			ppi_pkg::ACC_WY_ADD: accy_q <= accy_q + ext_prod;
			default: ;
		endcase
		if (cmd.out_ld) begin
			px_out_q <= posx_q;
			py_out_q <= posy_q;
			hd_out_q <= head_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			posx_q <= '0;
			posy_q <= '0;
			head_q <= '0;
		end else begin
			case (cmd.acc_op)
				ppi_pkg::ACC_POS_X: posx_q <= posx_next;
				ppi_pkg::ACC_POS_Y: posy_q <= posy_next;
				ppi_pkg::ACC_HEAD:  head_q <= head_q + turn;
				default: ;
			endcase
		end
	end

	assign pose_x = px_out_q;
	assign pose_y = py_out_q;
	assign heading = hd_out_q;

endmodule

FILE: src/planar_pose_integrator.sv
// Dead-reckoning pose integrator. Each tick request carries elapsed_time in 2^-16 s; the
// block rotates the configured body velocity by the current heading, integrates x and y
// (Q16.16, saturating) and then advances the heading (binary angle, wrapping) by yaw rate
// times elapsed time. A tick is accepted only while the block is idle; it then steps through
// two sine table reads, seven passes through the one shared 34x25 multiplier, the heading
// update and the hand-off before it is idle again. A finished pose waits in an output
// register, so a new tick is taken while it is unread; the next pose is held back only
// while the one before it is still unread. Registers sit at byte addresses 0 (body_vel_x),
// 4 (body_vel_y), 8 (yaw_rate).
// top level: ppi_regs, ppi_ctrl, ppi_dp; depends on ppi_pkg
module planar_pose_integrator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ppi_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       tick_valid,
	output logic                       tick_ready,
	input  logic [23:0]                elapsed_time,
	output logic                       pose_valid,
	input  logic                       pose_ready,
	output logic signed [31:0]         pose_x,
	output logic signed [31:0]         pose_y,
	output logic [31:0]                heading
);

	ppi_pkg::ppi_cfg_t cfg;
	ppi_pkg::ppi_cmd_t cmd;

	ppi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ppi_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_ready (tick_ready),
		.pose_valid (pose_valid),
		.pose_ready (pose_ready),
		.cmd        (cmd)
	);

	ppi_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg),
		.elapsed_time (elapsed_time),
		.pose_x       (pose_x),
		.pose_y       (pose_y),
		.heading      (heading)
	);

endmodule
